/* hw/rtl/sfd_pkg.sv */
// ============================================================================
// Sensor frame deframer package
// Shared constants and controller/datapath interface types.
// ============================================================================
package sfd_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ADDR_W         = 40;
    localparam int FRAME_BYTES    = 16;
    localparam int CNT_W          = $clog2(FRAME_BYTES);
    localparam int SLOT_W         = 3;
    localparam int TDATA_W        = 136;

    localparam logic [7:0] SYNC_FIRST  = 8'hCA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;

    typedef struct packed {
        logic shift_en;
        logic idx_clr;
        logic idx_inc;
        logic rd_en;
        logic claim;
        logic res_hit;
        logic res_full;
        logic load_out;
    } sfd_cmd_t;

    typedef struct packed {
        logic sync_first;
        logic sync_second;
        logic hit;
        logic empty;
        logic idx_last;
        logic out_busy;
    } sfd_sts_t;

endpackage

/* hw/rtl/sfd_ctrl.sv */
// ============================================================================
// Sensor frame deframer controller
// Sync hunt, byte counting and sequencing of the slot table lookup.
// ============================================================================
module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  sfd_sts_t sts,
    output sfd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_PARSE = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign s_tready = state_reg inside {ST_IDLE, ST_START, ST_PARSE};
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && sts.sync_first) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (accept && sts.sync_second) begin
                    state_next = ST_PARSE;
                    cnt_next   = '0;
                end
            end
            ST_PARSE: begin
                if (accept) begin
                    cmd.shift_en = 1'b1;
                    if (cnt_reg == CNT_W'(FRAME_BYTES - 1)) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_READ;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.hit) begin
                    cmd.res_hit = 1'b1;
                    state_next  = ST_EMIT;
                end else if (sts.empty) begin
                    cmd.claim   = 1'b1;
                    cmd.res_hit = 1'b1;
                    state_next  = ST_EMIT;
                end else if (sts.idx_last) begin
                    cmd.res_full = 1'b1;
                    state_next   = ST_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hw/rtl/sfd_datapath.sv */
// ============================================================================
// Sensor frame deframer datapath
// Frame byte shift line, sender slot table and output register.
// ============================================================================
module sfd_datapath
    import sfd_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_tdata,
    input  sfd_cmd_t           cmd,
    output sfd_sts_t           sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [7:0]            fb_reg [FRAME_BYTES];
    logic [ADDR_W-1:0]     mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [ADDR_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic                  full_reg;
    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic [ADDR_W-1:0]     addr;
    logic [ADDR_W-1:0]     entry;
    logic [IDX_W+2:0]      slot_ext;

    assign addr     = {fb_reg[0], fb_reg[1], fb_reg[2], fb_reg[3], fb_reg[4]};
    assign entry    = rd_valid_reg ? rd_data_reg : '0;
    assign slot_ext = {3'b000, slot_reg};

    assign sts.sync_first  = (s_tdata == SYNC_FIRST);
    assign sts.sync_second = (s_tdata == SYNC_SECOND);
    assign sts.hit         = (entry == addr);
    assign sts.empty       = (entry == '0);
    assign sts.idx_last    = (idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign sts.out_busy    = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.shift_en) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                fb_reg[i] <= fb_reg[i+1];
            end
            fb_reg[FRAME_BYTES-1] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.claim) begin
            mem[idx_reg] <= addr;
        end
        if (cmd.rd_en) begin
            rd_data_reg  <= mem[idx_reg];
            rd_valid_reg <= valid_reg[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.claim) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.res_hit) begin
            slot_reg <= idx_reg;
            full_reg <= 1'b0;
        end else if (cmd.res_full) begin
            slot_reg <= '0;
            full_reg <= 1'b1;
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {4'b0000,
                            fb_reg[14], fb_reg[15],
                            fb_reg[13],
                            fb_reg[11], fb_reg[12],
                            fb_reg[9], fb_reg[10],
                            fb_reg[7], fb_reg[8],
                            fb_reg[6],
                            fb_reg[5],
                            addr,
                            full_reg,
                            slot_ext[2:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/sensor_frame_deframer_top.sv */
// ============================================================================
// Sensor frame deframer
// Recovers 18-byte sensor frames from a byte stream and assigns sender slots.
// ============================================================================
// Usage:
// The slave channel takes one received byte per item on s_tdata. The block
// hunts for the sync pair 0xCA, 0x55 and then collects 16 frame bytes.
// While receiving, one byte is accepted every cycle.
// After the last frame byte, s_tready drops while the slot table is
// searched, each slot probed by a memory read and then a compare, and
// stays low while the result is loaded into the output register.
// The master channel then offers one result item holding the slot, the
// table full flag and the decoded frame fields.
// Reset empties the slot table and the output register and restarts the
// sync hunt. If the receiver stalls, the result is held in the output
// register while the next frame is still received; the block then waits
// after that frame's lookup until the register is free.
// ============================================================================
module sensor_frame_deframer_top
    import sfd_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [2:0] slot_index, [3] table_full, [43:4] sender_address,
    // [51:44] device_flag_bits, [59:52] error_flag_bits,
    // [75:60] temperature_raw, [91:76] humidity_raw, [107:92] supply_raw,
    // [115:108] link_quality, [131:116] frame_number, [135:132] zero
    output logic [TDATA_W-1:0] m_tdata
);

    sfd_cmd_t cmd;
    sfd_sts_t sts;

    sfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfd_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_claim_only_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.claim |-> (sts.empty && !sts.hit))
        else $error("Slot claimed that is not empty or already matches.");

    a_no_input_during_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en || cmd.res_hit || cmd.res_full) |-> !s_tready)
        else $error("Input accepted during slot lookup.");

    a_result_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.load_out))
        else $error("Result item appeared without an output load.");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_tvalid && !m_tready))
        else $error("Output register overwritten while stalled.");

endmodule
